>>> rtl/mds_pkg.sv
// Shared types, constants and helpers for the masked diffusion stencil.
package mds_pkg;

  localparam int unsigned GridWidthDef  = 32;
  localparam int unsigned GridHeightDef = 32;

  localparam int unsigned AmtW    = 16;
  localparam int unsigned IdxW    = 12;
  localparam int unsigned VolW    = 28;
  localparam int unsigned SumW    = 19;  // five 16-bit amounts
  localparam int unsigned CntW    = 3;   // one to five cells: the center plus its open neighbors
  localparam int unsigned RecipSh = 21;
  localparam int unsigned RecipW  = RecipSh + 1;
  localparam int unsigned ProdW   = SumW + RecipW;

  localparam logic [VolW-1:0] VolumeMax = {VolW{1'b1}};

  typedef struct packed {
    logic            frame_start;
    logic [AmtW-1:0] cell_amount;
    logic            cell_solid;
  } in_beat_t;

  typedef struct packed {
    logic [IdxW-1:0] cell_index;
    logic [AmtW-1:0] new_amount;
    logic            last_cell;
    logic [VolW-1:0] total_volume;
  } out_beat_t;

  typedef struct packed {
    logic            solid;
    logic [AmtW-1:0] amount;
  } cell_t;

  // Neighbors of the center cell as seen when the cell below it arrives.
  typedef struct packed {
    cell_t above;
    cell_t left;
    cell_t center;
    cell_t right;
  } mds_taps_t;

  // floor(x / cnt) == (x * recip(cnt)) >> RecipSh for any x below 2**SumW.
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] r;
    unique case (cnt)
      3'd2:    r = RecipW'(1) << (RecipSh - 1);
      3'd3:    r = RecipW'(699051);
      3'd4:    r = RecipW'(1) << (RecipSh - 2);
      3'd5:    r = RecipW'(419431);
      default: r = RecipW'(1) << RecipSh;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/mds_linebuf.sv
// Two-row line buffer that exposes the stencil neighborhood taps.
module mds_linebuf #(
  parameter int unsigned GRID_WIDTH = mds_pkg::GridWidthDef
) (
  input  logic              clk_i,
  input  logic              shift_i,
  input  mds_pkg::cell_t    cell_i,
  output mds_pkg::mds_taps_t taps_o
);
  import mds_pkg::*;

  localparam int unsigned Depth = 2 * GRID_WIDTH;

  // line_q[j] holds the cell that arrived j+1 beats ago
  cell_t line_q [Depth];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      line_q[0] <= cell_i;
      for (int unsigned j = 1; j < Depth; j++) begin
        line_q[j] <= line_q[j-1];
      end
    end
  end

  assign taps_o.right  = line_q[GRID_WIDTH-2];
  assign taps_o.center = line_q[GRID_WIDTH-1];
  assign taps_o.left   = line_q[GRID_WIDTH];
  assign taps_o.above  = line_q[Depth-1];

endmodule

>>> rtl/masked_diffusion_stencil_top.sv
// Top level of the masked diffusion stencil: raster position, pipeline, running total.
// Four register stages; stage 1 registers a cell's masked sum at the edge that accepts the cell
// directly below it, and stage 4 is the output register. Throughput, while not stalled:
// one cell per cycle; a stage advances whenever the next one is empty or moving.
// The line buffer is a 2*GRID_WIDTH-deep shift line, so results trail their cell by one row.
// Reset clears stage valids, raster position and total; line buffer contents are not cleared.
module masked_diffusion_stencil_top #(
  parameter int unsigned GRID_WIDTH  = mds_pkg::GridWidthDef,
  parameter int unsigned GRID_HEIGHT = mds_pkg::GridHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mds_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mds_pkg::out_beat_t out_beat_o
);
  import mds_pkg::*;

  localparam int unsigned ColW = $clog2(GRID_WIDTH);
  localparam int unsigned RowW = $clog2(GRID_HEIGHT);
  localparam int unsigned PosW = $clog2(GRID_WIDTH * GRID_HEIGHT);
  localparam int unsigned DifW = (PosW > IdxW) ? PosW : IdxW;

  localparam logic [ColW-1:0] ColLast = ColW'(GRID_WIDTH - 1);
  localparam logic [ColW-1:0] ColEnd  = ColW'(GRID_WIDTH - 2);
  localparam logic [RowW-1:0] RowLast = RowW'(GRID_HEIGHT - 1);
  localparam logic [RowW-1:0] RowTwo  = RowW'(2);

  // ---------------- handshake ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic free1, free2, free3, free4;
  logic in_acc;

  assign free4  = !out_valid_o || !out_stall_i;
  assign free3  = !v3_q || free4;
  assign free2  = !v2_q || free3;
  assign free1  = !v1_q || free2;
  assign in_stall_o = !free1;
  assign in_acc = in_valid_i && free1;

  // ---------------- raster position ----------------
  logic [ColW-1:0] col_q, col_d, col_e;
  logic [RowW-1:0] row_q, row_d, row_e;
  logic [PosW-1:0] pos_q, pos_d, pos_e;
  logic [DifW-1:0] idx_dif;

  always_comb begin
    col_e = in_beat_i.frame_start ? '0 : col_q;
    row_e = in_beat_i.frame_start ? '0 : row_q;
    pos_e = in_beat_i.frame_start ? '0 : pos_q;
    col_d = col_e + ColW'(1);
    row_d = row_e;
    pos_d = pos_e + PosW'(1);
    if (col_e == ColLast) begin
      col_d = '0;
      if (row_e == RowLast) begin
        row_d = '0;
        pos_d = '0;
      end else begin
        row_d = row_e + RowW'(1);
      end
    end
    idx_dif = DifW'(pos_e) - DifW'(GRID_WIDTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pos_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
      pos_q <= pos_d;
    end
  end

  // ---------------- line buffer ----------------
  cell_t     cell_in;
  mds_taps_t taps;

  assign cell_in.solid  = in_beat_i.cell_solid;
  assign cell_in.amount = in_beat_i.cell_amount;

  mds_linebuf #(
    .GRID_WIDTH(GRID_WIDTH)
  ) u_linebuf (
    .clk_i  (clk_i),
    .shift_i(in_acc),
    .cell_i (cell_in),
    .taps_o (taps)
  );

  // ---------------- stage 1: masked neighborhood sum ----------------
  logic [SumW-1:0] sum_c;
  logic [CntW-1:0] cnt_c;

  always_comb begin
    sum_c = SumW'(taps.center.amount);
    cnt_c = CntW'(1);
    if (!taps.right.solid) begin
      sum_c = sum_c + SumW'(taps.right.amount);
      cnt_c = cnt_c + CntW'(1);
    end
    if (!taps.left.solid) begin
      sum_c = sum_c + SumW'(taps.left.amount);
      cnt_c = cnt_c + CntW'(1);
    end
    if (!taps.above.solid) begin
      sum_c = sum_c + SumW'(taps.above.amount);
      cnt_c = cnt_c + CntW'(1);
    end
    if (!in_beat_i.cell_solid) begin
      sum_c = sum_c + SumW'(in_beat_i.cell_amount);
      cnt_c = cnt_c + CntW'(1);
    end
  end

  logic [SumW-1:0] s1_sum_q;
  logic [CntW-1:0] s1_cnt_q;
  logic            s1_open_q, s1_prod_q, s1_last_q, s1_clr_q;
  logic [IdxW-1:0] s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (free1) begin
      s1_sum_q  <= sum_c;
      s1_cnt_q  <= cnt_c;
      s1_open_q <= !taps.center.solid;
      s1_prod_q <= (row_e >= RowTwo) && (col_e != '0) && (col_e <= ColEnd);
      s1_last_q <= (row_e == RowLast) && (col_e == ColEnd);
      s1_clr_q  <= (pos_e == '0);
      s1_idx_q  <= idx_dif[IdxW-1:0];
    end
  end

  // ---------------- stage 2: reciprocal multiply ----------------
  logic [ProdW-1:0] s2_prod_q;
  logic             s2_ge_q, s2_prod_en_q, s2_last_q, s2_clr_q;
  logic [IdxW-1:0]  s2_idx_q;

  always_ff @(posedge clk_i) begin
    if (free2) begin
      s2_prod_q    <= ProdW'(s1_sum_q) * ProdW'(recip(s1_cnt_q));
      s2_ge_q      <= s1_open_q && (s1_sum_q >= SumW'(s1_cnt_q));
      s2_prod_en_q <= s1_prod_q;
      s2_last_q    <= s1_last_q;
      s2_clr_q     <= s1_clr_q;
      s2_idx_q     <= s1_idx_q;
    end
  end

  // ---------------- stage 3: quotient minus one ----------------
  logic [AmtW-1:0] quot;
  logic [AmtW-1:0] s3_val_q;
  logic            s3_prod_q, s3_last_q, s3_clr_q;
  logic [IdxW-1:0] s3_idx_q;

  assign quot = s2_prod_q[RecipSh +: AmtW];

  always_ff @(posedge clk_i) begin
    if (free3) begin
      s3_val_q  <= (s2_ge_q && s2_prod_en_q) ? quot - AmtW'(1) : '0;
      s3_prod_q <= s2_prod_en_q;
      s3_last_q <= s2_last_q;
      s3_clr_q  <= s2_clr_q;
      s3_idx_q  <= s2_idx_q;
    end
  end

  // ---------------- stage 4: running total and output register ----------------
  logic [VolW-1:0] vol_q, vol_d;
  logic [VolW:0]   vol_sum;
  logic            s4_prod_q;
  out_beat_t       out_q;

  always_comb begin
    vol_sum = (s3_clr_q ? '0 : {1'b0, vol_q}) + (VolW + 1)'(s3_val_q);
    vol_d   = (vol_sum > {1'b0, VolumeMax}) ? VolumeMax : vol_sum[VolW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= '0;
    end else if (free4 && v3_q) begin
      vol_q <= vol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free4) begin
      s4_prod_q          <= s3_prod_q;
      out_q.cell_index   <= s3_idx_q;
      out_q.new_amount   <= s3_val_q;
      out_q.last_cell    <= s3_last_q;
      out_q.total_volume <= vol_d;
    end
  end

  // ---------------- stage valids ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (free1) v1_q <= in_acc;
      if (free2) v2_q <= v1_q;
      if (free3) v3_q <= v2_q;
      if (free4) v4_q <= v3_q;
    end
  end

  // drop border cells at the output register
  assign out_valid_o = v4_q && s4_prod_q;
  assign out_beat_o  = out_q;

endmodule

>>> rtl/mds_check.sv
// Port-level checker for the masked diffusion stencil, bound to the top level.
module mds_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input mds_pkg::in_beat_t  in_beat_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mds_pkg::out_beat_t out_beat_o
);
  import mds_pkg::*;

  // a stalled cell beat holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_beat_i))
    else $error("cell beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result beat offered during reset");

  // input is only held back by a full, stalled output register
  a_no_false_stall: assert property (@(posedge clk_i)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while the pipeline can advance");

  // the running total includes the current result
  a_total_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.total_volume >= VolW'(out_beat_o.new_amount)))
    else $error("total below the current result");

endmodule

bind masked_diffusion_stencil_top mds_check u_mds_check (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_beat_i  (in_beat_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_beat_o (out_beat_o)
);
